### rtl/core/nsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsv_pkg;

   // Section layout
   localparam logic [4:0]  HdrBytes    = 5'd24;
   localparam logic [4:0]  HdrCrcSpan  = 5'd20;
   localparam logic [4:0]  OffMagicEnd = 5'd3;
   localparam logic [4:0]  OffUserEnd  = 5'd7;
   localparam logic [4:0]  OffType     = 5'd8;
   localparam logic [4:0]  OffLenEnd   = 5'd15;
   localparam logic [4:0]  OffDcrcEnd  = 5'd19;
   localparam logic [4:0]  OffHdrEnd   = 5'd23;
   localparam logic [31:0] EntryMin    = 32'd10;
   localparam logic [3:0]  EntryHead   = 4'd8;
   localparam logic [3:0]  EntryLastLen = 4'd7;

   localparam logic [31:0] MagicReset = 32'hB32C41B4;
   localparam logic [31:0] CrcPoly    = 32'hEDB88320;
   localparam logic [31:0] CrcPreset  = 32'hFFFFFFFF;

   // Register map (index = byte address / 4)
   localparam logic [0:0] RegMagic = 1'b0;

   // Result beat layout
   localparam int RspBits = 80;

   typedef enum logic [1:0] {
      HDR_OK      = 2'd0,
      HDR_CRC_BAD = 2'd1,
      HDR_BAD     = 2'd2
   } hdr_status_type;

   typedef enum logic [2:0] {
      DATA_OK        = 3'd0,
      DATA_UNCHECKED = 3'd1,
      DATA_SHORT     = 3'd2,
      DATA_CRC_BAD   = 3'd3,
      DATA_MALFORMED = 3'd4
   } data_status_type;

   // Reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/core/nvram_section_validator_top.sv
// Section validator: checks one stored section image streamed a byte per beat.
//
// Input channel (req_): one byte per beat in req_tdata, req_tlast on the final
// byte of the section. Result channel (rsp_): one beat per section, issued for
// the beat that carried req_tlast, holding header and data verdicts plus the
// user counter, record type and data length from the header.
// Configuration: APB-style port, register 0 at address 0 is the expected magic
// word (resets to 0xB32C41B4). Write it only while no section is in flight.
//
// Throughput: one byte per cycle while no last byte waits on a stalled result.
// Each byte passes an input register and then a single update stage (byte-wide
// CRC-32 step, header capture, entry walk counters); the result register is
// loaded by that same stage.
// The input is accepted while a result waits; only a last byte that meets a
// full, stalled result register holds in the input register and stops req_.
// Reset (synchronous, active high) empties both registers, returns the walk
// to the start of a section and restores the magic word. After each result
// the section state returns to its reset values, so the next byte opens a
// new section.
`timescale 1ns / 1ps
`default_nettype none

module nvram_section_validator_top
   import nsv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // input stream
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] data_byte
   input  wire logic                req_tlast,   // last_byte
   // result stream
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspBits-1:0]       rsp_tdata,   // [1:0] header_status, [4:2] data_status,
                                                 // [36:5] user_counter, [44:37] record_type,
                                                 // [76:45] data_length, [79:77] zero
   // configuration
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [2:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   // Configuration register
   logic [31:0] magic_word_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == RegMagic);
   assign csr_prdata = (csr_paddr[2] == RegMagic) ? magic_word_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff <= MagicReset;
      end else if (csr_wr) begin
         magic_word_ff <= csr_pwdata;
      end
   end

   // Input register and flow control
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, s1_go, req_take, rsp_load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_load   = s1_go && s1_last_ff;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // Section state
   logic [4:0]  cnt_ff, cnt_in;           // header bytes taken, saturates at 24
   logic [31:0] crc_ff, crc_in;
   logic [31:0] hshift_ff, hshift_in;
   logic [31:0] magic_seen_ff, magic_seen_in;
   logic [31:0] user_ff, user_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] dcrc_ff, dcrc_in;
   logic [1:0]  verdict_ff, verdict_in;
   logic [31:0] rem_ff, rem_in;           // data bytes still expected
   logic [3:0]  phase_ff, phase_in;
   logic [63:0] ent_ff, ent_in;
   logic [32:0] left_ff, left_in;
   logic        fault_ff, fault_in;

   logic [63:0]     ent_next;
   logic [32:0]     body;
   logic [32:0]     left_dec;
   logic [31:0]     rest;
   hdr_status_type  hs_res;
   data_status_type ds_res;
   logic [31:0]     user_res, len_res;
   logic [7:0]      type_res;

   assign ent_next = {s1_byte_ff, ent_ff[63:8]};
   assign body     = {1'b0, ent_next[31:0]} + {1'b0, ent_next[63:32]};
   assign left_dec = left_ff - 33'd1;
   assign rest     = rem_ff - 32'd1;

   always_comb begin
      cnt_in        = cnt_ff;
      crc_in        = crc_ff;
      hshift_in     = hshift_ff;
      magic_seen_in = magic_seen_ff;
      user_in       = user_ff;
      type_in       = type_ff;
      len_in        = len_ff;
      dcrc_in       = dcrc_ff;
      verdict_in    = verdict_ff;
      rem_in        = rem_ff;
      phase_in      = phase_ff;
      ent_in        = ent_ff;
      left_in       = left_ff;
      fault_in      = fault_ff;
      hs_res        = HDR_OK;
      ds_res        = DATA_OK;
      user_res      = 32'd0;
      type_res      = 8'd0;
      len_res       = 32'd0;

      if (s1_go) begin
         // Header bytes: gather little-endian words and run the header CRC
         if (cnt_ff < HdrBytes) begin
            hshift_in = {s1_byte_ff, hshift_ff[31:8]};
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff < HdrCrcSpan) begin
               crc_in = crc_byte(crc_ff, s1_byte_ff);
            end
            if (cnt_ff == OffMagicEnd) magic_seen_in = hshift_in;
            if (cnt_ff == OffUserEnd)  user_in       = hshift_in;
            if (cnt_ff == OffType)     type_in       = s1_byte_ff;
            if (cnt_ff == OffLenEnd)   len_in        = hshift_in;
            if (cnt_ff == OffDcrcEnd)  dcrc_in       = hshift_in;
            if (cnt_ff == OffHdrEnd) begin
               if (~crc_ff != hshift_in) begin
                  verdict_in = HDR_CRC_BAD;
               end else if (magic_seen_ff != magic_word_ff) begin
                  verdict_in = HDR_BAD;
               end else begin
                  verdict_in = HDR_OK;
               end
               crc_in = CrcPreset;
               rem_in = len_ff;
            end
         end else if (rem_ff != 32'd0) begin
            // Data bytes within the declared length
            crc_in = crc_byte(crc_ff, s1_byte_ff);
            rem_in = rest;
            if (!fault_ff) begin
               if (phase_ff == EntryHead) begin
                  // skip the entry body
                  left_in = left_dec;
                  if (left_dec == 33'd0) phase_in = 4'd0;
               end else if (phase_ff == 4'd0 && rem_ff < EntryMin) begin
                  fault_in = 1'b1;
               end else begin
                  ent_in   = ent_next;
                  phase_in = phase_ff + 4'd1;
                  if (phase_ff == EntryLastLen) begin
                     if (body > {1'b0, rest}) begin
                        fault_in = 1'b1;
                     end else if (body == 33'd0) begin
                        phase_in = 4'd0;
                     end else begin
                        left_in = body;
                     end
                  end
               end
            end
         end

         // Verdict on the last byte, then return to the start of a section
         if (s1_last_ff) begin
            if (cnt_in < HdrBytes) begin
               hs_res = HDR_BAD;
               ds_res = DATA_UNCHECKED;
            end else if (verdict_in != HDR_OK) begin
               hs_res = hdr_status_type'(verdict_in);
               ds_res = DATA_UNCHECKED;
            end else begin
               user_res = user_in;
               type_res = type_in;
               len_res  = len_in;
               if (rem_in != 32'd0) begin
                  ds_res = DATA_SHORT;
               end else if (~crc_in != dcrc_in) begin
                  ds_res = DATA_CRC_BAD;
               end else if (fault_in) begin
                  ds_res = DATA_MALFORMED;
               end else begin
                  ds_res = DATA_OK;
               end
            end
            cnt_in        = 5'd0;
            crc_in        = CrcPreset;
            hshift_in     = 32'd0;
            magic_seen_in = 32'd0;
            user_in       = 32'd0;
            type_in       = 8'd0;
            len_in        = 32'd0;
            dcrc_in       = 32'd0;
            verdict_in    = HDR_OK;
            rem_in        = 32'd0;
            phase_in      = 4'd0;
            ent_in        = 64'd0;
            left_in       = 33'd0;
            fault_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= 5'd0;
         crc_ff        <= CrcPreset;
         hshift_ff     <= 32'd0;
         magic_seen_ff <= 32'd0;
         user_ff       <= 32'd0;
         type_ff       <= 8'd0;
         len_ff        <= 32'd0;
         dcrc_ff       <= 32'd0;
         verdict_ff    <= HDR_OK;
         rem_ff        <= 32'd0;
         phase_ff      <= 4'd0;
         ent_ff        <= 64'd0;
         left_ff       <= 33'd0;
         fault_ff      <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         crc_ff        <= crc_in;
         hshift_ff     <= hshift_in;
         magic_seen_ff <= magic_seen_in;
         user_ff       <= user_in;
         type_ff       <= type_in;
         len_ff        <= len_in;
         dcrc_ff       <= dcrc_in;
         verdict_ff    <= verdict_in;
         rem_ff        <= rem_in;
         phase_ff      <= phase_in;
         ent_ff        <= ent_in;
         left_ff       <= left_in;
         fault_ff      <= fault_in;
      end
   end

   // Result register
   logic [RspBits-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {3'd0, len_res, type_res, user_res, ds_res, hs_res};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/core/nsv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nsv_checker
   import nsv_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [RspBits-1:0] rsp_tdata
);

   logic [1:0] hs;
   logic [2:0] ds;

   assign hs = rsp_tdata[1:0];
   assign ds = rsp_tdata[4:2];

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Bad header leaves data unchecked and header fields cleared
   a_hdr_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hs != HDR_OK |->
         ds == DATA_UNCHECKED && rsp_tdata[76:5] == 72'd0)
      else $error("bad header with data verdict or fields");

   // Only defined status codes leave the block
   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hs == HDR_OK || hs == HDR_CRC_BAD || hs == HDR_BAD) &&
         (ds == DATA_OK || ds == DATA_UNCHECKED || ds == DATA_SHORT ||
          ds == DATA_CRC_BAD || ds == DATA_MALFORMED) && rsp_tdata[79:77] == 3'd0)
      else $error("undefined status code or padding");

   // Drop any pending result on reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind nvram_section_validator_top nsv_checker u_nsv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import nsv_pkg::*;

   localparam int          HeaderLen      = 24;
   localparam int          HeaderCrcLen   = 20;
   localparam int          EntryFloor     = 10;
   localparam logic [32:0] PosSaturated   = {33{1'b1}};
   localparam logic [3:0]  WalkBody       = 4'd8;
   localparam logic [2:0]  MagicAddr      = 3'd0;
   localparam logic [2:0]  SpareAddr      = 3'd4;
   localparam int          PhaseCount     = 5;
   localparam int          PhaseBytes     = 120;
   localparam int          SettleCycles   = 4;
   localparam int          HoldOffCycles  = 400;
   localparam int          WatchdogLimit  = 2000;

   typedef enum int {
      SEC_GOOD,
      SEC_TRAILING,
      SEC_EMPTY_ENTRY,
      SEC_MALFORMED,
      SEC_HUGE_ENTRY,
      SEC_DATA_CRC,
      SEC_DATA_SHORT,
      SEC_HDR_CRC,
      SEC_BAD_MAGIC,
      SEC_MAX_LEN,
      SEC_TOO_SHORT,
      SEC_NOISE
   } section_kind_type;

   typedef struct packed {
      hdr_status_type  hdr;
      data_status_type data;
      logic [31:0]     user;
      logic [7:0]      rtype;
      logic [31:0]     dlen;
   } section_verdict_type;

   // Section predictor and verdict checker
   class section_scoreboard;
      logic [31:0]         magic;
      int                  errors;
      int                  verdicts;
      int                  bytes_seen;
      int                  hdr_tally[3];
      int                  data_tally[5];
      section_verdict_type pending_q[$];

      logic [32:0]      pos;
      logic [31:0]      crc;
      logic [31:0]      gather;
      logic [31:0]      magic_f;
      logic [31:0]      user_f;
      logic [7:0]       type_f;
      logic [31:0]      len_f;
      logic [31:0]      dcrc_f;
      hdr_status_type   hdr_verdict;
      logic [3:0]       walk_phase;
      logic [63:0]      walk_lens;
      logic [33:0]      walk_left;
      bit               walk_fault;

      function new();
         magic = MagicReset;
         errors = 0;
         verdicts = 0;
         bytes_seen = 0;
         foreach (hdr_tally[i]) hdr_tally[i] = 0;
         foreach (data_tally[i]) data_tally[i] = 0;
         clear();
      endfunction

      static function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'h0, b};
         for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (CrcPoly & {32{r[0]}});
         end
         return r;
      endfunction

      function void clear();
         pos = '0;
         crc = '1;
         gather = '0;
         magic_f = '0;
         user_f = '0;
         type_f = '0;
         len_f = '0;
         dcrc_f = '0;
         hdr_verdict = HDR_OK;
         walk_phase = '0;
         walk_lens = '0;
         walk_left = '0;
         walk_fault = 1'b0;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 30) begin
            $display("ERROR: %s", msg);
         end else if (errors == 31) begin
            $display("ERROR: further faults counted, not shown");
         end
      endfunction

      // Entry walk over one data byte at data index d
      function void walk(logic [32:0] d, logic [7:0] b);
         logic [33:0] body;
         logic [33:0] rest;
         if (walk_fault) return;
         if (walk_phase == WalkBody) begin
            walk_left--;
            if (walk_left == 0) walk_phase = '0;
            return;
         end
         if (walk_phase == 0) begin
            walk_lens = '0;
            if ({1'b0, len_f} - d < 33'(EntryFloor)) begin
               walk_fault = 1'b1;
               return;
            end
         end
         walk_lens[8*walk_phase +: 8] = b;
         walk_phase++;
         if (walk_phase == WalkBody) begin
            body = {2'b0, walk_lens[31:0]} + {2'b0, walk_lens[63:32]};
            rest = {1'b0, {1'b0, len_f} - d - 33'd1};
            if (body > rest) begin
               walk_fault = 1'b1;
            end else if (body == 0) begin
               walk_phase = '0;
            end else begin
               walk_left = body;
            end
         end
      endfunction

      // Advance the section state by one accepted byte; queue a verdict on the last
      function void note_byte(logic [7:0] b, logic last);
         logic [32:0]         d;
         section_verdict_type v;
         bytes_seen++;
         if (pos != PosSaturated) begin
            if (pos < 33'(HeaderLen)) begin
               gather = {b, gather[31:8]};
               if (pos < 33'(HeaderCrcLen)) crc = crc32_step(crc, b);
               case (pos[4:0])
                  OffMagicEnd: magic_f = gather;
                  OffUserEnd:  user_f = gather;
                  OffType:     type_f = b;
                  OffLenEnd:   len_f = gather;
                  OffDcrcEnd:  dcrc_f = gather;
                  OffHdrEnd: begin
                     if (~crc != gather) hdr_verdict = HDR_CRC_BAD;
                     else if (magic_f != magic) hdr_verdict = HDR_BAD;
                     else hdr_verdict = HDR_OK;
                     crc = '1;
                  end
                  default: ;
               endcase
            end else begin
               d = pos - 33'(HeaderLen);
               if (d < {1'b0, len_f}) begin
                  crc = crc32_step(crc, b);
                  walk(d, b);
               end
            end
            pos++;
         end
         if (!last) return;

         v = '0;
         if (pos < 33'(HeaderLen)) begin
            v.hdr = HDR_BAD;
            v.data = DATA_UNCHECKED;
         end else if (hdr_verdict != HDR_OK) begin
            v.hdr = hdr_verdict;
            v.data = DATA_UNCHECKED;
         end else begin
            v.hdr = HDR_OK;
            v.user = user_f;
            v.rtype = type_f;
            v.dlen = len_f;
            if (pos - 33'(HeaderLen) < {1'b0, len_f}) v.data = DATA_SHORT;
            else if (~crc != dcrc_f) v.data = DATA_CRC_BAD;
            else if (walk_fault) v.data = DATA_MALFORMED;
            else v.data = DATA_OK;
         end
         hdr_tally[int'(v.hdr)]++;
         data_tally[int'(v.data)]++;
         pending_q.push_back(v);
         clear();
      endfunction

      function void compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report($sformatf("verdict %0d %s: got %0h, want %0h", verdicts, name, got, want));
         end
      endfunction

      function void check_result(logic [RspBits-1:0] beat);
         section_verdict_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("result beat %h with no section outstanding", beat));
            return;
         end
         want = pending_q.pop_front();
         verdicts++;
         compare_field("header_status", 32'(beat[1:0]), 32'(want.hdr));
         compare_field("data_status", 32'(beat[4:2]), 32'(want.data));
         compare_field("user_counter", beat[36:5], want.user);
         compare_field("record_type", 32'(beat[44:37]), 32'(want.rtype));
         compare_field("data_length", beat[76:45], want.dlen);
         compare_field("pad", 32'(beat[79:77]), 32'd0);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;   // [7:0] data_byte
   logic                req_tlast;   // last_byte
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspBits-1:0]  rsp_tdata;   // [1:0] header_status, [4:2] data_status,
                                     // [36:5] user_counter, [44:37] record_type,
                                     // [76:45] data_length, [79:77] zero
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [2:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   section_scoreboard   sb;
   logic [7:0]          sec_q[$];
   int                  bytes_sent = 0;
   int                  burst_left = 0;
   int                  quiet_cycles = 0;
   bit                  hold_off_req = 1'b0;

   nvram_section_validator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch both channels; feed the predictor and the checker
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("ERROR: no beat accepted for %0d cycles", quiet_cycles);
            $display("nvram_section_validator_top: mismatch");
            $finish;
         end
      end
   end

   // Result side: stall on a pattern of its own, and hold off on request
   initial begin : result_sink
      int mode;
      int span;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 80);
         for (int i = 0; i < span && !hold_off_req; i++) begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ((i % 5) < 2);
            endcase
            @(posedge clock);
         end
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off_req = 1'b0;
         end
      end
   end

   function automatic logic [31:0] nonzero_mask();
      logic [31:0] m;
      m = $urandom;
      return (m == 0) ? 32'h1 : m;
   endfunction

   function automatic void push_le32(logic [31:0] w);
      for (int k = 0; k < 4; k++) sec_q.push_back(w[8*k +: 8]);
   endfunction

   function automatic void set_le32(int at, logic [31:0] w);
      for (int k = 0; k < 4; k++) sec_q[at+k] = w[8*k +: 8];
   endfunction

   function automatic logic [31:0] crc_span(int from, int n);
      logic [31:0] c;
      c = '1;
      for (int i = 0; i < n; i++) c = section_scoreboard::crc32_step(c, sec_q[from+i]);
      return ~c;
   endfunction

   // Data length: zero or at least one entry's worth, mostly small
   function automatic int unsigned pick_len(bit nonempty);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0 && !nonempty) return 0;
      if (r == 9) return $urandom_range(10, 200);
      return $urandom_range(10, 48);
   endfunction

   // Well-formed entries filling exactly total bytes (total is 0 or at least 10)
   function automatic void add_entries(int unsigned total);
      int unsigned left;
      int unsigned span;
      int unsigned klen;
      left = total;
      while (left > 0) begin
         if (left < 18 || $urandom_range(0, 2) == 0) span = left - 8;
         else span = $urandom_range(0, left - 18);
         klen = $urandom_range(0, span);
         push_le32(klen);
         push_le32(span - klen);
         repeat (span) sec_q.push_back(8'($urandom));
         left -= span + 8;
      end
   endfunction

   // Assemble one section image of the given flavour into sec_q
   function automatic void build_section(section_kind_type kind, int variant, logic [31:0] magic);
      int unsigned dlen;
      int unsigned keep;
      int unsigned span;
      logic [31:0] hdr_magic;
      logic [31:0] dcrc;
      logic [31:0] hcrc;
      sec_q.delete();
      if (kind == SEC_NOISE) begin
         repeat ($urandom_range(1, 60)) sec_q.push_back(8'($urandom));
         return;
      end
      repeat (HeaderLen) sec_q.push_back(8'h00);

      // data region
      if (kind == SEC_MALFORMED || (kind == SEC_DATA_CRC && variant % 2 == 1)) begin
         case (variant % 3)
            0: begin
               add_entries(pick_len(1'b1));
               sec_q[HeaderLen+3] |= 8'h80;
            end
            1: repeat ($urandom_range(1, 9)) sec_q.push_back(8'($urandom));
            default: begin
               span = $urandom_range(0, 30);
               push_le32(span);
               push_le32(32'd0);
               repeat (span) sec_q.push_back(8'($urandom));
               repeat ($urandom_range(1, 9)) sec_q.push_back(8'($urandom));
            end
         endcase
      end else if (kind == SEC_HUGE_ENTRY) begin
         push_le32(32'hFFFF_FFFF);
         push_le32($urandom_range(1, 8));
         repeat ($urandom_range(8, 16)) sec_q.push_back(8'($urandom));
      end else if (kind == SEC_EMPTY_ENTRY) begin
         push_le32(32'd0);
         push_le32(32'd0);
         add_entries(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(10, 30));
      end else if (kind == SEC_DATA_SHORT) begin
         add_entries(pick_len(1'b1));
      end else if (kind == SEC_GOOD && variant == 1) begin
         add_entries(0);
      end else begin
         add_entries(pick_len(1'b0));
      end
      dlen = sec_q.size() - HeaderLen;

      // header fields
      dcrc = crc_span(HeaderLen, dlen);
      if (kind == SEC_DATA_CRC) dcrc ^= nonzero_mask();
      hdr_magic = magic;
      if (kind == SEC_BAD_MAGIC || (kind == SEC_HDR_CRC && variant % 2 == 1)) begin
         hdr_magic ^= nonzero_mask();
      end
      set_le32(0, hdr_magic);
      set_le32(4, $urandom);
      set_le32(8, $urandom);
      set_le32(12, (kind == SEC_MAX_LEN) ? 32'hFFFF_FFFF : dlen);
      set_le32(16, dcrc);
      hcrc = crc_span(0, HeaderCrcLen);
      if (kind == SEC_HDR_CRC) hcrc ^= nonzero_mask();
      set_le32(20, hcrc);

      // stream length adjustments
      if (kind == SEC_DATA_SHORT) begin
         repeat ($urandom_range(1, dlen)) void'(sec_q.pop_back());
      end
      if (kind == SEC_TRAILING) begin
         repeat ($urandom_range(1, 20)) sec_q.push_back(8'($urandom));
      end
      if (kind == SEC_TOO_SHORT) begin
         keep = (variant >= 1 && variant < HeaderLen) ? variant : $urandom_range(1, HeaderLen - 1);
         while (sec_q.size() > keep) void'(sec_q.pop_back());
      end
   endfunction

   // Offer sec_q byte by byte in bursts with random gaps
   task automatic send_section();
      for (int i = 0; i < sec_q.size(); i++) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 24);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left--;
         req_tvalid <= 1'b1;
         req_tdata <= sec_q[i];
         req_tlast <= (i == sec_q.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         bytes_sent++;
      end
   endtask

   task automatic run_section(section_kind_type kind, int variant);
      build_section(kind, variant, sb.magic);
      send_section();
   endtask

   // Drop the input and let every outstanding verdict drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == MagicAddr) sb.magic = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_magic();
      logic [31:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= MagicAddr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== sb.magic) begin
         sb.report($sformatf("magic_word read %h, want %h", got, sb.magic));
      end
   endtask

   function automatic section_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return SEC_GOOD;
      if (r < 58) return SEC_TRAILING;
      if (r < 62) return SEC_EMPTY_ENTRY;
      if (r < 70) return SEC_MALFORMED;
      if (r < 73) return SEC_HUGE_ENTRY;
      if (r < 79) return SEC_DATA_CRC;
      if (r < 85) return SEC_DATA_SHORT;
      if (r < 89) return SEC_HDR_CRC;
      if (r < 93) return SEC_BAD_MAGIC;
      if (r < 95) return SEC_MAX_LEN;
      if (r < 97) return SEC_TOO_SHORT;
      return SEC_NOISE;
   endfunction

   initial begin : stimulus
      logic [31:0] magic_plan[PhaseCount];
      int          phase_start;
      sb = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      req_tlast <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of the magic word, then the directed sections
      csr_check_magic();
      run_section(SEC_TOO_SHORT, 1);
      run_section(SEC_TOO_SHORT, HeaderLen - 1);
      run_section(SEC_GOOD, 1);
      run_section(SEC_GOOD, 0);
      run_section(SEC_EMPTY_ENTRY, 0);
      run_section(SEC_TRAILING, 0);
      run_section(SEC_HDR_CRC, 0);
      run_section(SEC_HDR_CRC, 1);
      run_section(SEC_BAD_MAGIC, 0);
      run_section(SEC_DATA_SHORT, 0);
      run_section(SEC_MAX_LEN, 0);
      run_section(SEC_DATA_CRC, 0);
      run_section(SEC_DATA_CRC, 1);
      run_section(SEC_MALFORMED, 0);
      run_section(SEC_MALFORMED, 1);
      run_section(SEC_MALFORMED, 2);
      run_section(SEC_HUGE_ENTRY, 0);
      run_section(SEC_NOISE, 0);
      wait_idle();

      // Random sections over several magic word settings
      magic_plan[0] = 32'h0000_0000;
      magic_plan[1] = 32'hFFFF_FFFF;
      magic_plan[2] = $urandom;
      magic_plan[3] = MagicReset;
      magic_plan[4] = $urandom;
      for (int phase = 0; phase < PhaseCount; phase++) begin
         csr_write(MagicAddr, magic_plan[phase]);
         if (phase == 3) csr_write(SpareAddr, $urandom);
         csr_check_magic();
         if (phase == 1) hold_off_req = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PhaseBytes) begin
            run_section(pick_kind(), $urandom_range(0, 30));
         end
         wait_idle();
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d section bytes and %0d verdicts under %0d magic word settings.",
               sb.bytes_seen, sb.verdicts, PhaseCount + 1);
      $display("Header ok/crc/bad %0d/%0d/%0d; data ok/unchk/short/crc/bad %0d/%0d/%0d/%0d/%0d.",
               sb.hdr_tally[0], sb.hdr_tally[1], sb.hdr_tally[2], sb.data_tally[0],
               sb.data_tally[1], sb.data_tally[2], sb.data_tally[3], sb.data_tally[4]);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("nvram_section_validator_top: match");
      end else begin
         $display("nvram_section_validator_top: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/nsv_pkg.sv
rtl/core/nvram_section_validator_top.sv
rtl/core/nsv_checker.sv
tb/tb.sv
